/* rtl/sfr_pkg.sv */
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types and constants of the serial frame receiver with checksum.
// ----------------------------------------------------------------------------
package sfr_pkg;

    // framing bytes
    localparam logic [7:0] HDR_FIRST  = 8'hFE;
    localparam logic [7:0] HDR_SECOND = 8'hEF;
    localparam logic [7:0] FTR_FIRST  = 8'h0D;
    localparam logic [7:0] FTR_SECOND = 8'h0A;

    // reset value of the length limit
    localparam logic [15:0] MAX_LEN_RESET = 16'hFFFF;

    // result kinds
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_FRAME   = 1'b1;

    // receive phases
    typedef enum logic [3:0] {
        PH_HUNT1 = 4'd0,
        PH_HUNT2 = 4'd1,
        PH_CMD   = 4'd2,
        PH_LENH  = 4'd3,
        PH_LENL  = 4'd4,
        PH_DATA  = 4'd5,
        PH_CHKH  = 4'd6,
        PH_CHKL  = 4'd7,
        PH_FTR1  = 4'd8,
        PH_FTR2  = 4'd9
    } phase_t;

    // frame status codes
    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_FOOTER_ERR = 2'd1,
        ST_LENGTH_ERR = 2'd2
    } status_t;

    // one result record
    typedef struct packed {
        logic        kind;
        logic [7:0]  payload_byte;
        logic [15:0] byte_index;
        logic [7:0]  command;
        logic [15:0] payload_length;
        logic [15:0] checksum_received;
        logic        checksum_match;
        status_t     status;
        logic        last;
    } result_t;

    // queue fill state seen by the front and the back
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

/* rtl/sfr_parser.sv */
// ----------------------------------------------------------------------------
// sfr_parser
// Front end: takes received bytes, tracks the frame phase and builds result
// records for payload bytes, frame completion and length errors.
// ----------------------------------------------------------------------------
module sfr_parser (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [15:0]      cfg_wr_data,
    input  logic             byte_fire,
    input  logic [7:0]       rx_byte,
    output logic             res_valid,
    output sfr_pkg::result_t res
);
    import sfr_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [7:0]  command_reg, command_next;
    logic [15:0] length_reg, length_next;
    logic [15:0] count_reg, count_next;
    logic [15:0] sum_reg, sum_next;
    logic [15:0] rxsum_reg, rxsum_next;
    logic        ftr_ok_reg, ftr_ok_next;
    logic [15:0] max_len_reg;
    logic [15:0] new_length;
    logic [15:0] count_inc;

    // length limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= MAX_LEN_RESET;
        end
        else if (cfg_wr_en)
        begin
            max_len_reg <= cfg_wr_data;
        end
    end

    // phase and frame state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HUNT1;
            command_reg <= '0;
            length_reg  <= '0;
            count_reg   <= '0;
            sum_reg     <= '0;
            rxsum_reg   <= '0;
            ftr_ok_reg  <= 1'b0;
        end
        else if (byte_fire)
        begin
            phase_reg   <= phase_next;
            command_reg <= command_next;
            length_reg  <= length_next;
            count_reg   <= count_next;
            sum_reg     <= sum_next;
            rxsum_reg   <= rxsum_next;
            ftr_ok_reg  <= ftr_ok_next;
        end
    end

    assign new_length = {length_reg[15:8], rx_byte};
    assign count_inc  = count_reg + 16'd1;

    // next phase and result record
    always_comb
    begin
        phase_next   = PH_HUNT1;
        command_next = command_reg;
        length_next  = length_reg;
        count_next   = count_reg;
        sum_next     = sum_reg;
        rxsum_next   = rxsum_reg;
        ftr_ok_next  = ftr_ok_reg;

        res_valid             = 1'b0;
        res.kind              = KIND_FRAME;
        res.payload_byte      = '0;
        res.byte_index        = '0;
        res.command           = command_reg;
        res.payload_length    = length_reg;
        res.checksum_received = '0;
        res.checksum_match    = 1'b0;
        res.status            = ST_OK;
        res.last              = 1'b1;

        case (phase_reg)
            PH_HUNT2:
            begin
                if (rx_byte == HDR_SECOND)
                    phase_next = PH_CMD;
                else if (rx_byte == HDR_FIRST)
                    phase_next = PH_HUNT2;
                else
                    phase_next = PH_HUNT1;
            end
            PH_CMD:
            begin
                command_next = rx_byte;
                phase_next   = PH_LENH;
            end
            PH_LENH:
            begin
                length_next = {rx_byte, 8'h00};
                phase_next  = PH_LENL;
            end
            PH_LENL:
            begin
                length_next        = new_length;
                count_next         = '0;
                sum_next           = '0;
                rxsum_next         = '0;
                res.payload_length = new_length;
                if (new_length > max_len_reg)
                begin
                    // oversized frame, report and hunt again
                    phase_next = PH_HUNT1;
                    res_valid  = 1'b1;
                    res.status = ST_LENGTH_ERR;
                end
                else if (new_length == '0)
                    phase_next = PH_CHKH;
                else
                    phase_next = PH_DATA;
            end
            PH_DATA:
            begin
                sum_next         = sum_reg + {8'h00, rx_byte};
                count_next       = count_inc;
                phase_next       = (count_inc == length_reg) ? PH_CHKH : PH_DATA;
                res_valid        = 1'b1;
                res.kind         = KIND_PAYLOAD;
                res.payload_byte = rx_byte;
                res.byte_index   = count_reg;
                res.last         = 1'b0;
            end
            PH_CHKH:
            begin
                rxsum_next = {rx_byte, 8'h00};
                phase_next = PH_CHKL;
            end
            PH_CHKL:
            begin
                rxsum_next = {rxsum_reg[15:8], rx_byte};
                phase_next = PH_FTR1;
            end
            PH_FTR1:
            begin
                ftr_ok_next = (rx_byte == FTR_FIRST);
                phase_next  = PH_FTR2;
            end
            PH_FTR2:
            begin
                // frame completion
                phase_next            = PH_HUNT1;
                res_valid             = 1'b1;
                res.checksum_received = rxsum_reg;
                res.checksum_match    = (sum_reg == rxsum_reg);
                res.status = (ftr_ok_reg && rx_byte == FTR_SECOND) ? ST_OK : ST_FOOTER_ERR;
            end
            default:
            begin
                phase_next = (rx_byte == HDR_FIRST) ? PH_HUNT2 : PH_HUNT1;
            end
        endcase

        if (!byte_fire)
            res_valid = 1'b0;
    end

endmodule

/* rtl/sfr_queue.sv */
// ----------------------------------------------------------------------------
// sfr_queue
// Small result queue between the parser and the output stage.
// ----------------------------------------------------------------------------
module sfr_queue #(
    parameter int DEPTH = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       wr_en,
    input  sfr_pkg::result_t           wr_data,
    input  logic                       rd_en,
    output sfr_pkg::result_t           rd_data,
    output sfr_pkg::queue_status_t     stat,
    output logic [$clog2(DEPTH+1)-1:0] fill
);
    import sfr_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    result_t         mem_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            do_wr;
    logic            do_rd;

    assign stat.full  = (count_reg == CW'(DEPTH));
    assign stat.empty = (count_reg == '0);
    assign fill       = count_reg;
    assign do_wr      = wr_en && !stat.full;
    assign do_rd      = rd_en && !stat.empty;
    assign rd_data    = mem_reg[rd_ptr_reg];

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        if (do_wr && !do_rd)
            count_next = count_reg + CW'(1);
        else if (do_rd && !do_wr)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

/* rtl/sfr_out.sv */
// ----------------------------------------------------------------------------
// sfr_out
// Back end: pulls result records from the queue into the output register
// and holds them until the receiver takes the transfer.
// ----------------------------------------------------------------------------
module sfr_out (
    input  logic                   clk,
    input  logic                   rst_n,
    input  sfr_pkg::queue_status_t q_stat,
    input  sfr_pkg::result_t       q_data,
    output logic                   q_pop,
    input  logic                   out_stall,
    output logic                   out_valid,
    output sfr_pkg::result_t       out_res
);
    import sfr_pkg::*;

    logic    valid_reg, valid_next;
    result_t res_reg;

    // load when the register is empty or being taken
    assign q_pop      = !q_stat.empty && (!valid_reg || !out_stall);
    assign valid_next = q_pop ? 1'b1 : (valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            res_reg <= q_data;
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

/* rtl/serial_frame_receiver_checksum_core.sv */
// ----------------------------------------------------------------------------
// serial_frame_receiver_checksum_core
// Recovers FE EF / command / length / payload / checksum / 0D 0A frames from
// a byte stream, passes payload bytes on and reports each frame's outcome.
// ----------------------------------------------------------------------------
// Input channel: rx_byte with in_valid / in_stall, one byte per transfer.
// Output channel: one result per transfer with out_valid / out_stall; kind 0
// carries a payload byte and its index, kind 1 (last set) closes a frame
// with command, length, received checksum, checksum match and status.
// Bytes that produce no result (header, length, checksum, first footer byte)
// are still consumed at one per cycle while in_stall is low.
// Configuration: cfg_wr_en writes cfg_wr_data into the length limit.
// Throughput: one byte per cycle while in_stall is low; each result is registered
// into the queue and then into the output register, where out_stall holds it.
// in_stall rises only when the result queue holds QUEUE_DEPTH entries, which
// happens only while the receiver keeps out_stall high.
// Reset: asynchronous, active low; the parser goes back to hunting FE, the
// queue and output register empty, the length limit returns to 65535.
// ----------------------------------------------------------------------------
module serial_frame_receiver_checksum_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        kind,
    output logic [7:0]  payload_byte,
    output logic [15:0] byte_index,
    output logic [7:0]  command,
    output logic [15:0] payload_length,
    output logic [15:0] checksum_received,
    output logic        checksum_match,
    output logic [1:0]  status,
    output logic        last
);
    import sfr_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic          byte_fire;
    logic          res_valid;
    result_t       res;
    result_t       q_data;
    queue_status_t q_stat;
    logic [CW-1:0] q_fill;
    logic          q_pop;
    result_t       out_res;

    // front end takes a transfer whenever the queue has room
    assign in_stall  = q_stat.full;
    assign byte_fire = in_valid && !in_stall;

    sfr_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .byte_fire   (byte_fire),
        .rx_byte     (rx_byte),
        .res_valid   (res_valid),
        .res         (res)
    );

    sfr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_valid),
        .wr_data (res),
        .rd_en   (q_pop),
        .rd_data (q_data),
        .stat    (q_stat),
        .fill    (q_fill)
    );

    sfr_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_stat    (q_stat),
        .q_data    (q_data),
        .q_pop     (q_pop),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_res   (out_res)
    );

    // result fields onto the ports
    assign kind              = out_res.kind;
    assign payload_byte      = out_res.payload_byte;
    assign byte_index        = out_res.byte_index;
    assign command           = out_res.command;
    assign payload_length    = out_res.payload_length;
    assign checksum_received = out_res.checksum_received;
    assign checksum_match    = out_res.checksum_match;
    assign status            = out_res.status;
    assign last              = out_res.last;

    // no result is written into a full queue
    assert property (@(posedge clk) disable iff (!rst_n) !(res_valid && q_stat.full))
        else $error("result written into full queue");

    // queue fill never passes its depth
    assert property (@(posedge clk) disable iff (!rst_n) q_fill <= CW'(QUEUE_DEPTH))
        else $error("queue fill beyond depth");

    // payload results are never marked as frame end
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind == KIND_PAYLOAD) |-> (!last && status == ST_OK))
        else $error("payload result marked as frame end");

    // a length error carries no checksum
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_LENGTH_ERR)
            |-> (!checksum_match && checksum_received == '0))
        else $error("length error carries checksum fields");

endmodule

/* tb/tb_serial_frame_receiver_checksum_core.sv */
// ----------------------------------------------------------------------------
// tb_serial_frame_receiver_checksum_core
// Drives byte streams into the frame receiver and checks every result. The
// streams are directed framing corner cases followed by random frames, noise
// and truncated frames under several length limits. A predictor tracks the
// parser state and queues the expected payload and completion results.
// Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_serial_frame_receiver_checksum_core;

    timeunit 1ns;
    timeprecision 1ps;

    import sfr_pkg::*;

    localparam int CLK_HALF      = 6;
    localparam int SETTLE_CYCLES = 6;
    localparam int DRAIN_LIMIT   = 4000;
    localparam int MAX_REPORTS   = 10;
    localparam int PHASE_ITEMS   = 200;

    // dut signals
    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [15:0] cfg_wr_data = '0;
    logic        in_valid    = 1'b0;
    logic        in_stall;
    logic [7:0]  rx_byte     = '0;
    logic        out_valid;
    logic        out_stall   = 1'b0;
    logic        kind;
    logic [7:0]  payload_byte;
    logic [15:0] byte_index;
    logic [7:0]  command;
    logic [15:0] payload_length;
    logic [15:0] checksum_received;
    logic        checksum_match;
    logic [1:0]  status;
    logic        last;

    // predictor state
    phase_t      rx_phase  = PH_HUNT1;
    logic [7:0]  cur_cmd   = '0;
    logic [15:0] cur_len   = '0;
    logic [15:0] pay_count = '0;
    logic [15:0] pay_sum   = '0;
    logic [15:0] chk_rx    = '0;
    logic        ftr1_ok   = 1'b0;
    logic [15:0] len_limit = MAX_LEN_RESET;

    result_t     pending_results[$];
    int          fail_count = 0;
    int          sent_count = 0;
    int unsigned gap_max    = 3;
    int unsigned stall_max  = 3;

    serial_frame_receiver_checksum_core i_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .rx_byte           (rx_byte),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .kind              (kind),
        .payload_byte      (payload_byte),
        .byte_index        (byte_index),
        .command           (command),
        .payload_length    (payload_length),
        .checksum_received (checksum_received),
        .checksum_match    (checksum_match),
        .status            (status),
        .last              (last)
    );

    // clock
    initial
    begin
        forever #(CLK_HALF) clk = ~clk;
    end

    // run limit
    initial
    begin
        #5ms;
        $display("serial_frame_receiver_checksum_core test failed");
        $finish;
    end

    // advance the parser by one byte, queue the result it causes
    function automatic void predict_rx_byte(input logic [7:0] b);
        result_t r;
        logic    have_result;
        r = '0;
        have_result = 1'b0;
        case (rx_phase)
            PH_HUNT2:
                rx_phase = (b == HDR_SECOND) ? PH_CMD :
                           (b == HDR_FIRST)  ? PH_HUNT2 : PH_HUNT1;
            PH_CMD:
            begin
                cur_cmd  = b;
                rx_phase = PH_LENH;
            end
            PH_LENH:
            begin
                cur_len  = {b, 8'h00};
                rx_phase = PH_LENL;
            end
            PH_LENL:
            begin
                cur_len[7:0] = b;
                pay_count    = '0;
                pay_sum      = '0;
                chk_rx       = '0;
                if (cur_len > len_limit)
                begin
                    rx_phase    = PH_HUNT1;
                    r.kind      = KIND_FRAME;
                    r.status    = ST_LENGTH_ERR;
                    r.last      = 1'b1;
                    have_result = 1'b1;
                end
                else
                begin
                    rx_phase = (cur_len == 16'd0) ? PH_CHKH : PH_DATA;
                end
            end
            PH_DATA:
            begin
                r.kind         = KIND_PAYLOAD;
                r.payload_byte = b;
                r.byte_index   = pay_count;
                have_result    = 1'b1;
                pay_sum        = pay_sum + {8'h00, b};
                pay_count      = pay_count + 16'd1;
                if (pay_count == cur_len)
                    rx_phase = PH_CHKH;
            end
            PH_CHKH:
            begin
                chk_rx   = {b, 8'h00};
                rx_phase = PH_CHKL;
            end
            PH_CHKL:
            begin
                chk_rx[7:0] = b;
                rx_phase    = PH_FTR1;
            end
            PH_FTR1:
            begin
                ftr1_ok  = (b == FTR_FIRST);
                rx_phase = PH_FTR2;
            end
            PH_FTR2:
            begin
                r.kind              = KIND_FRAME;
                r.checksum_received = chk_rx;
                r.checksum_match    = (pay_sum == chk_rx);
                r.status            = (ftr1_ok && b == FTR_SECOND) ? ST_OK : ST_FOOTER_ERR;
                r.last              = 1'b1;
                have_result         = 1'b1;
                rx_phase            = PH_HUNT1;
            end
            default:
                rx_phase = (b == HDR_FIRST) ? PH_HUNT2 : PH_HUNT1;
        endcase
        if (have_result)
        begin
            r.command        = cur_cmd;
            r.payload_length = cur_len;
            pending_results.push_back(r);
        end
    endfunction

    function automatic string result_text(input result_t r);
        return {$sformatf("kind=%0d byte=%02h idx=%0d cmd=%02h len=%0d ",
                          r.kind, r.payload_byte, r.byte_index, r.command,
                          r.payload_length),
                $sformatf("chk=%04h ok=%0d st=%0d last=%0d",
                          r.checksum_received, r.checksum_match, r.status, r.last)};
    endfunction

    // names of the fields that differ
    function automatic string field_diffs(input result_t got, input result_t want);
        string s;
        s = "";
        if (got.kind !== want.kind)                           s = {s, " kind"};
        if (got.payload_byte !== want.payload_byte)           s = {s, " payload_byte"};
        if (got.byte_index !== want.byte_index)               s = {s, " byte_index"};
        if (got.command !== want.command)                     s = {s, " command"};
        if (got.payload_length !== want.payload_length)       s = {s, " payload_length"};
        if (got.checksum_received !== want.checksum_received) s = {s, " checksum_received"};
        if (got.checksum_match !== want.checksum_match)       s = {s, " checksum_match"};
        if (got.status !== want.status)                       s = {s, " status"};
        if (got.last !== want.last)                           s = {s, " last"};
        return s;
    endfunction

    function automatic void note_failure(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("[%0t] %s", $realtime, msg);
    endfunction

    // result checker and output stall generator
    initial
    begin : result_monitor
        result_t     got;
        result_t     want;
        string       diffs;
        int unsigned rest_cycles;
        rest_cycles = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                got.kind              = kind;
                got.payload_byte      = payload_byte;
                got.byte_index        = byte_index;
                got.command           = command;
                got.payload_length    = payload_length;
                got.checksum_received = checksum_received;
                got.checksum_match    = checksum_match;
                got.status            = status_t'(status);
                got.last              = last;
                if (pending_results.size() == 0)
                begin
                    note_failure({"unexpected result: ", result_text(got)});
                end
                else
                begin
                    want  = pending_results.pop_front();
                    diffs = field_diffs(got, want);
                    if (diffs != "")
                        note_failure({"mismatch in", diffs, "\n  expected ",
                                      result_text(want), "\n  actual   ", result_text(got)});
                end
                rest_cycles = $urandom_range(0, stall_max);
            end
            @(negedge clk);
            if (rest_cycles > 0)
            begin
                out_stall <= 1'b1;
                rest_cycles--;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // one byte transfer; starts and ends at a falling edge
    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        gap = $urandom_range(0, gap_max);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (in_stall);
        predict_rx_byte(b);
        sent_count++;
        @(negedge clk);
    endtask

    // whole or truncated frame; cut < 0 sends all of it
    task automatic send_frame(input logic [7:0] cmd, input int len, input logic [15:0] chk_flip,
                              input logic [7:0] f1, input logic [7:0] f2, input int cut);
        logic [7:0]  fb[$];
        logic [7:0]  pb;
        logic [15:0] sum;
        sum = '0;
        fb.push_back(HDR_FIRST);
        fb.push_back(HDR_SECOND);
        fb.push_back(cmd);
        fb.push_back(len[15:8]);
        fb.push_back(len[7:0]);
        for (int i = 0; i < len; i++)
        begin
            pb  = 8'($urandom_range(0, 255));
            sum = sum + {8'h00, pb};
            fb.push_back(pb);
        end
        sum = sum ^ chk_flip;
        fb.push_back(sum[15:8]);
        fb.push_back(sum[7:0]);
        fb.push_back(f1);
        fb.push_back(f2);
        for (int i = 0; i < fb.size() && (cut < 0 || i < cut); i++)
            send_byte(fb[i]);
    endtask

    // hold the sender off until every expected result has been seen
    task automatic wait_for_drain();
        int n;
        n = 0;
        in_valid <= 1'b0;
        while (pending_results.size() > 0 && n < DRAIN_LIMIT)
        begin
            @(negedge clk);
            n++;
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_length_limit(input logic [15:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        len_limit    = v;
        @(negedge clk);
    endtask

    // hunt restarts, repeated first header byte, good one-byte frame
    task automatic test_header_hunt();
        send_byte(8'h00);
        send_byte(HDR_FIRST);
        send_byte(8'h12);
        send_byte(HDR_FIRST);
        send_frame(8'hFF, 1, 16'h0000, FTR_FIRST, FTR_SECOND, -1);
    endtask

    // empty payload with a wrong checksum and a wrong second footer byte
    task automatic test_zero_length_bad_footer();
        send_frame(8'h00, 0, 16'h1234, FTR_FIRST, 8'h0B, -1);
    endtask

    // largest length against the smallest limit, then limit back to its top
    task automatic test_length_limit();
        wait_for_drain();
        set_length_limit(16'h0000);
        send_frame(8'h55, 65535, 16'h0000, FTR_FIRST, FTR_SECOND, 5);
        wait_for_drain();
        set_length_limit(16'hFFFF);
    endtask

    // payload long enough to carry the index past one byte
    task automatic test_long_payload();
        send_frame(8'($urandom_range(0, 255)), 300, 16'h0000, FTR_FIRST, FTR_SECOND, -1);
    endtask

    // random mix of frames, truncated frames and noise under one limit
    task automatic test_random_traffic(input logic [15:0] limit, input int unsigned gaps,
                                       input int unsigned stalls);
        int          start;
        int          pick;
        int          len;
        int          cut;
        logic [15:0] flip;
        logic [7:0]  f1;
        logic [7:0]  f2;
        wait_for_drain();
        set_length_limit(limit);
        gap_max   = gaps;
        stall_max = stalls;
        start     = sent_count;
        while (sent_count - start < PHASE_ITEMS)
        begin
            pick = int'($urandom_range(0, 99));
            if (pick < 10)
            begin
                repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
            end
            else
            begin
                // lengths around a small limit hit the reject boundary
                if (limit <= 64 && $urandom_range(0, 3) == 0)
                    len = int'(limit) + int'($urandom_range(0, 2)) - 1;
                else
                    len = int'($urandom_range(0, 8));
                if (len < 0)
                    len = 0;
                flip = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 65535)) : 16'h0000;
                f1   = FTR_FIRST;
                f2   = FTR_SECOND;
                if ($urandom_range(0, 6) == 0)
                begin
                    if ($urandom_range(0, 1) == 1)
                        f1 = 8'($urandom_range(0, 255));
                    else
                        f2 = 8'($urandom_range(0, 255));
                end
                cut = (pick < 20) ? int'($urandom_range(1, 8 + len)) : -1;
                send_frame(8'($urandom_range(0, 255)), len, flip, f1, f2, cut);
            end
        end
    endtask

    // test sequence
    initial
    begin
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_header_hunt();
        test_zero_length_bad_footer();
        test_length_limit();
        test_long_payload();
        test_random_traffic(16'hFFFF, 3, 3);
        test_random_traffic(16'h0000, 3, 3);
        test_random_traffic(16'd6, 0, 0);
        test_random_traffic(16'($urandom_range(1, 20)), 0, 3);
        test_random_traffic(16'($urandom_range(0, 65535)), 3, 0);

        wait_for_drain();
        if (pending_results.size() != 0)
            note_failure($sformatf("%0d expected results never arrived",
                                   pending_results.size()));
        if (fail_count == 0)
            $display("serial_frame_receiver_checksum_core test passed");
        else
            $display("serial_frame_receiver_checksum_core test failed");
        $finish;
    end

endmodule
